// File: hdl/lru_page_buffer_directory_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the page buffer directory
// ---------------------------------------------------------------------------
`ifndef LRU_PAGE_BUFFER_DIRECTORY_MACROS_SVH
`define LRU_PAGE_BUFFER_DIRECTORY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LPBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/lpbd_pkg.sv
// ---------------------------------------------------------------------------
// lpbd_pkg
// shared types and constants of the page buffer directory
// ---------------------------------------------------------------------------
package lpbd_pkg;
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 20;
    localparam int TABLE_W       = 8;
    localparam int CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic update;
    } lpbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
    } lpbd_stat_t;
endpackage

// File: hdl/lpbd_req_if.sv
// ---------------------------------------------------------------------------
// lpbd_req_if
// request channel: valid/ready with request word
// ---------------------------------------------------------------------------
interface lpbd_req_if #(
    parameter int PAGE_BITS = lpbd_pkg::PAGE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [lpbd_pkg::TABLE_W-1:0] table_id;
    logic [PAGE_BITS-1:0]         page_id;

    modport source (output valid, req_type, table_id, page_id, input ready);
    modport sink (input valid, req_type, table_id, page_id, output ready);
endinterface

// File: hdl/lpbd_rsp_if.sv
// ---------------------------------------------------------------------------
// lpbd_rsp_if
// result channel: valid/ready with result word
// ---------------------------------------------------------------------------
interface lpbd_rsp_if #(
    parameter int FRAMES    = lpbd_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpbd_pkg::PAGE_BITS_DEF
);
    localparam int SW = $clog2(FRAMES);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [SW-1:0]                frame_slot;
    logic                         disk_read;
    logic                         disk_write;
    logic                         evicted_valid;
    logic [lpbd_pkg::TABLE_W-1:0] evicted_table;
    logic [PAGE_BITS-1:0]         evicted_page;

    modport source (output valid, hit, frame_slot, disk_read, disk_write, evicted_valid,
        evicted_table, evicted_page, input ready);
    modport sink (input valid, hit, frame_slot, disk_read, disk_write, evicted_valid,
        evicted_table, evicted_page, output ready);
endinterface

// File: hdl/lpbd_ctrl.sv
// ---------------------------------------------------------------------------
// lpbd_ctrl
// request sequencer: capture, lookup/update, result hand-off
// ---------------------------------------------------------------------------
`include "lru_page_buffer_directory_macros.svh"
module lpbd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lpbd_pkg::lpbd_cmd_t  cmd,
    input  lpbd_pkg::lpbd_stat_t stat
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WORK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.update = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !stat.busy;
                if (in_valid && !stat.busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `LPBD_ASSERT_IMPL(a_one_cmd, clk, rst_n, cmd.load, !cmd.update)
    `LPBD_ASSERT_NEXT(a_load_to_work, clk, rst_n, cmd.load, state_reg == ST_WORK)
    `LPBD_ASSERT_NEXT(a_update_to_out, clk, rst_n, cmd.update, out_valid)
endmodule

// File: hdl/lpbd_dp.sv
// ---------------------------------------------------------------------------
// lpbd_dp
// tag store, recency ranks, hit/victim/free search and result register
// ---------------------------------------------------------------------------
`include "lru_page_buffer_directory_macros.svh"
module lpbd_dp #(
    parameter int FRAMES    = lpbd_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpbd_pkg::PAGE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lpbd_pkg::lpbd_cmd_t            cmd,
    output lpbd_pkg::lpbd_stat_t           stat,
    input  logic                           cfg_we,
    input  logic [lpbd_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                           req_type,
    input  logic [lpbd_pkg::TABLE_W-1:0]   table_id,
    input  logic [PAGE_BITS-1:0]           page_id,
    output logic                           hit,
    output logic [$clog2(FRAMES)-1:0]      frame_slot,
    output logic                           disk_read,
    output logic                           disk_write,
    output logic                           evicted_valid,
    output logic [lpbd_pkg::TABLE_W-1:0]   evicted_table,
    output logic [PAGE_BITS-1:0]           evicted_page
);
    localparam int SW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int TW = lpbd_pkg::TABLE_W;
    localparam int KW = lpbd_pkg::CAP_W;

    logic [KW-1:0]        cap_reg;
    logic                 rq_type_reg;
    logic [TW-1:0]        rq_table_reg;
    logic [PAGE_BITS-1:0] rq_page_reg;
    logic [FRAMES-1:0]    valid_reg;
    logic [TW-1:0]        ttag_reg [FRAMES];
    logic [PAGE_BITS-1:0] ptag_reg [FRAMES];
    logic [SW-1:0]        rank_reg [FRAMES];
    logic [CW-1:0]        count_reg;

    logic [FRAMES-1:0] match;
    logic              found;
    logic [SW-1:0]     hit_idx;
    logic [SW-1:0]     victim;
    logic [SW-1:0]     free_idx;
    logic              free_found;
    logic [FRAMES-1:0] valid_after;
    logic [CW-1:0]     eff_cap;
    logic              do_evict;
    logic [SW-1:0]     hit_rank;

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CW'(1);
        else if (32'(cap_reg) > FRAMES)
            eff_cap = CW'(FRAMES);
        else
            eff_cap = CW'(cap_reg);
    end

    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        victim  = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && ttag_reg[i] == rq_table_reg
                && ptag_reg[i] == rq_page_reg;
            if (match[i])
            begin
                found   = 1'b1;
                hit_idx = SW'(i);
            end
            // ranks of valid frames are distinct, oldest is count-1
            if (valid_reg[i] && CW'(rank_reg[i]) == count_reg - CW'(1))
                victim = SW'(i);
        end
        hit_rank = rank_reg[hit_idx];
        do_evict = !found && count_reg >= eff_cap && count_reg != '0;
        valid_after = valid_reg;
        if (do_evict)
            valid_after[victim] = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!valid_after[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    assign stat.busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= lpbd_pkg::CAP_RESET;
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (cmd.update)
            begin
                if (found)
                begin
                    for (int i = 0; i < FRAMES; i++)
                        if (valid_reg[i] && rank_reg[i] < hit_rank)
                            rank_reg[i] <= rank_reg[i] + SW'(1);
                    rank_reg[hit_idx] <= '0;
                end
                else if (free_found)
                begin
                    for (int i = 0; i < FRAMES; i++)
                        if (valid_after[i])
                            rank_reg[i] <= rank_reg[i] + SW'(1);
                    rank_reg[free_idx] <= '0;
                    valid_reg <= valid_after | (FRAMES'(1) << free_idx);
                    count_reg <= do_evict ? count_reg : count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rq_type_reg  <= req_type;
            rq_table_reg <= table_id;
            rq_page_reg  <= page_id;
        end
        if (cmd.update)
        begin
            if (!found && free_found)
            begin
                ttag_reg[free_idx] <= rq_table_reg;
                ptag_reg[free_idx] <= rq_page_reg;
            end
            hit           <= found;
            frame_slot    <= found ? hit_idx : free_idx;
            disk_read     <= !found && rq_type_reg == lpbd_pkg::REQ_READ;
            disk_write    <= rq_type_reg == lpbd_pkg::REQ_WRITE;
            evicted_valid <= do_evict;
            evicted_table <= do_evict ? ttag_reg[victim] : '0;
            evicted_page  <= do_evict ? ptag_reg[victim] : '0;
        end
    end

    `LPBD_ASSERT_IMPL(a_hit_onehot, clk, rst_n, cmd.update, $onehot0(match))
    `LPBD_ASSERT_IMPL(a_count_match, clk, rst_n, 1'b1, CW'($countones(valid_reg)) == count_reg)
    `LPBD_ASSERT_NEXT(a_free_after_miss, clk, rst_n, cmd.update && !found,
        valid_reg != '0)
endmodule

// File: hdl/lru_page_buffer_directory.sv
// ---------------------------------------------------------------------------
// lru_page_buffer_directory
// fully associative page buffer directory with lru replacement
// ---------------------------------------------------------------------------
// requests enter on req (valid/ready), one word per page access: read or
// write, table id and page id. each request yields one result word on rsp:
// hit flag, frame slot, disk read/write requests and any evicted page tags.
// an item is captured, then a parallel tag compare and rank update over all
// frames loads the result register, which is then offered. the sequencer
// holds a single request and takes no new word until rsp takes the result,
// so a stalled rsp holds off req. capacity_in_use is written through
// cfg_we/cfg_wdata; the user must write it only while idle, unenforced by
// the block. reset empties the directory at once and sets the capacity to 16.
// ---------------------------------------------------------------------------
module lru_page_buffer_directory #(
    parameter int FRAMES    = lpbd_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpbd_pkg::PAGE_BITS_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_we,
    input logic [lpbd_pkg::CAP_W-1:0] cfg_wdata,
    lpbd_req_if.sink                  req,
    lpbd_rsp_if.source                rsp
);
    lpbd_pkg::lpbd_cmd_t  cmd;
    lpbd_pkg::lpbd_stat_t stat;

    lpbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lpbd_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_type      (req.req_type),
        .table_id      (req.table_id),
        .page_id       (req.page_id),
        .hit           (rsp.hit),
        .frame_slot    (rsp.frame_slot),
        .disk_read     (rsp.disk_read),
        .disk_write    (rsp.disk_write),
        .evicted_valid (rsp.evicted_valid),
        .evicted_table (rsp.evicted_table),
        .evicted_page  (rsp.evicted_page)
    );
endmodule

// File: sim/tb_lru_page_buffer_directory.sv
// ---------------------------------------------------------------------------
// tb_lru_page_buffer_directory
// self-checking bench for the lru page buffer directory: an lru predictor
// runs on every accepted request word, result words are checked in order,
// capacity is swept across phases including 0, 1, 16 and 31
// ---------------------------------------------------------------------------
module tb_lru_page_buffer_directory;
    localparam int NF = lpbd_pkg::FRAMES_DEF;
    localparam int PB = lpbd_pkg::PAGE_BITS_DEF;

    typedef struct packed {
        logic          kind;
        logic [7:0]    tbl;
        logic [PB-1:0] page;
    } access_t;

    typedef struct packed {
        logic          hit;
        logic [3:0]    slot;
        logic          rd;
        logic          wr;
        logic          ev;
        logic [7:0]    ev_tbl;
        logic [PB-1:0] ev_page;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lpbd_pkg::CAP_W-1:0] cfg_wdata;

    lpbd_req_if #(.PAGE_BITS(PB)) req ();
    lpbd_rsp_if #(.FRAMES(NF), .PAGE_BITS(PB)) rsp ();

    lru_page_buffer_directory #(.FRAMES(NF), .PAGE_BITS(PB)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req.sink), .rsp(rsp.source)
    );

    access_t  pending_words[$];
    outcome_t expected_outcomes[$];
    int       errors;
    bit       calm;
    bit       send_hold;

    // predictor state
    logic [4:0]    cap_reg;
    bit            fv[NF];
    logic [7:0]    ftbl[NF];
    logic [PB-1:0] fpage[NF];
    int            frank[NF];
    int            occ;

    function automatic outcome_t lookup_page(access_t a);
        outcome_t o;
        int slot;
        int cap;
        int victim;
        int old;
        o = '0;
        slot = -1;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > NF) ? NF : int'(cap_reg));
        for (int i = 0; i < NF; i++)
            if (slot < 0 && fv[i] && ftbl[i] == a.tbl && fpage[i] == a.page)
                slot = i;
        if (slot >= 0)
        begin
            o.hit = 1'b1;
            old = frank[slot];
            for (int i = 0; i < NF; i++)
                if (fv[i] && i != slot && frank[i] < old)
                    frank[i]++;
            frank[slot] = 0;
        end
        else
        begin
            if (occ >= cap && occ > 0)
            begin
                victim = -1;
                for (int i = 0; i < NF; i++)
                    if (fv[i] && (victim < 0 || frank[i] > frank[victim]))
                        victim = i;
                o.ev = 1'b1;
                o.ev_tbl = ftbl[victim];
                o.ev_page = fpage[victim];
                fv[victim] = 0;
                occ--;
            end
            for (int i = NF - 1; i >= 0; i--)
                if (!fv[i])
                    slot = i;
            for (int i = 0; i < NF; i++)
                if (fv[i])
                    frank[i]++;
            fv[slot] = 1;
            ftbl[slot] = a.tbl;
            fpage[slot] = a.page;
            frank[slot] = 0;
            occ++;
        end
        o.slot = slot[3:0];
        o.rd = !o.hit && a.kind == lpbd_pkg::REQ_READ;
        o.wr = a.kind;
        return o;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.req_type <= 1'b0;
            req.table_id <= '0;
            req.page_id <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_outcomes.push_back(lookup_page(
                    access_t'{req.req_type, req.table_id, req.page_id}));
            if ((!req.valid || req.ready) && !send_hold)
            begin
                if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 23))
                begin
                    access_t a;
                    a = pending_words.pop_front();
                    req.valid <= 1'b1;
                    req.req_type <= a.kind;
                    req.table_id <= a.tbl;
                    req.page_id <= a.page;
                end
                else
                    req.valid <= 1'b0;
            end
            else if (req.valid && req.ready)
                req.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_outcomes.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    if (rsp.hit !== e.hit)
                        report_mismatch($sformatf("hit %b exp %b", rsp.hit, e.hit));
                    if (rsp.frame_slot !== e.slot)
                        report_mismatch($sformatf("slot %0d exp %0d", rsp.frame_slot, e.slot));
                    if (rsp.disk_read !== e.rd)
                        report_mismatch($sformatf("disk_read %b exp %b", rsp.disk_read, e.rd));
                    if (rsp.disk_write !== e.wr)
                        report_mismatch($sformatf("disk_write %b exp %b", rsp.disk_write, e.wr));
                    if (rsp.evicted_valid !== e.ev)
                        report_mismatch($sformatf("evicted_valid %b exp %b",
                            rsp.evicted_valid, e.ev));
                    if (rsp.evicted_table !== e.ev_tbl)
                        report_mismatch($sformatf("evicted_table %h exp %h",
                            rsp.evicted_table, e.ev_tbl));
                    if (rsp.evicted_page !== e.ev_page)
                        report_mismatch($sformatf("evicted_page %h exp %h",
                            rsp.evicted_page, e.ev_page));
                end
            end
            rsp.ready <= calm || $urandom_range(99) >= 23;
        end
    end

    task automatic add_word(logic kind, logic [7:0] t, logic [PB-1:0] p);
        pending_words.push_back(access_t'{kind, t, p});
    endtask

    task automatic drain();
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (req.valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_capacity(logic [4:0] c);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        cap_reg = c;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random traffic with a small working set so hits and evictions are common
    task automatic add_random(int n, int span);
        logic [7:0]    t;
        logic [PB-1:0] p;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
            begin
                t = 8'($urandom_range(span - 1)) ^ 8'hA5;
                p = PB'($urandom_range(span - 1)) ^ PB'('hC3A5F);
            end
            else
            begin
                t = 8'($urandom);
                p = PB'($urandom);
            end
            add_word(1'($urandom), t, p);
        end
    endtask

    initial
    begin
        automatic logic [4:0] caps[6] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd12};
        errors = 0;
        calm = 0;
        send_hold = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cap_reg = lpbd_pkg::CAP_RESET;
        occ = 0;
        for (int i = 0; i < NF; i++)
        begin
            fv[i] = 0;
            ftbl[i] = '0;
            fpage[i] = '0;
            frank[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, read and write hits and misses, fill and evict
        add_word(lpbd_pkg::REQ_READ, 8'h00, '0);
        add_word(lpbd_pkg::REQ_WRITE, 8'hFF, '1);
        add_word(lpbd_pkg::REQ_READ, 8'hFF, '1);
        add_word(lpbd_pkg::REQ_WRITE, 8'h00, '0);
        add_word(lpbd_pkg::REQ_READ, 8'h00, '1);
        for (int i = 0; i < 16; i++)
            add_word(1'(i), 8'(i * 17), PB'(i * 65537));
        add_word(lpbd_pkg::REQ_READ, 8'h00, '0);
        add_word(lpbd_pkg::REQ_WRITE, 8'h55, 20'hAAAAA);
        drain();

        // capacity sweep; in the third phase, hold off until everything has come back, then continue
        foreach (caps[k])
        begin
            set_capacity(caps[k]);
            if (k == 3)
                calm = 1;
            add_random(120, 24);
            if (k == 2)
            begin
                wait (pending_words.size() < 60);
                send_hold = 1;
                while (expected_outcomes.size() > 0 || req.valid)
                    @(posedge clk);
                send_hold = 0;
            end
            drain();
            calm = 0;
        end
        // lower capacity below occupancy
        set_capacity(5'd16);
        add_random(100, 40);
        drain();
        set_capacity(5'd3);
        add_random(200, 12);
        drain();
        set_capacity(5'd8);
        add_random(480, 20);
        drain();

        if (errors == 0)
            $display("[lru_page_buffer_directory] OK");
        else
            $display("[lru_page_buffer_directory] ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[lru_page_buffer_directory] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/lpbd_pkg.sv
hdl/lpbd_req_if.sv
hdl/lpbd_rsp_if.sv
hdl/lpbd_ctrl.sv
hdl/lpbd_dp.sv
hdl/lru_page_buffer_directory.sv
sim/tb_lru_page_buffer_directory.sv
